[design/chs_pkg.sv]
// Shared types and codes for the chained hash set.
package chs_pkg;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SPARE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MOD,
    BK_HEAD,
    BK_HWAIT,
    BK_NODE,
    BK_NWAIT,
    BK_ACT,
    BK_FREEWAIT,
    BK_FREE,
    BK_UNLINK,
    BK_OUT
  } back_state_e;

endpackage

[design/chained_hash_set_unit.sv]
// Top level of the chained hash set.
// Usage: push a request (req_type_i, key_i) when full is low; read found_o and
// status_o while empty is low and pulse pop to take the result. Each request
// gives one result, in order. A small input queue accepts up to two
// requests while the back end works on another one.
// The bucket is found by a restoring reduction of the key by the bucket count:
// shifted subtracts of the count, then a finishing step. The chain head is
// fetched next, the walk reads and compares each node visited, then the set is
// updated and the result posted. The back end takes a new request only once it
// is idle and the previous result has been popped.
// Reset empties all buckets, the free list and the pool, and sets the bucket
// count to 16. A bucket count write (cfg_we_i, cfg_wdata_i) is ignored while
// any chain is held. When the receiver stalls the result holds on the ports,
// the back end waits, and the input queue fills and raises full.
module chained_hash_set_unit #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024,
  parameter int KEY_BITS    = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                empty,
  input  logic                pop,
  output logic                found_o,
  output logic [1:0]          status_o
);

  logic                rq_valid, rq_take;
  chs_pkg::req_e       rq_type;
  logic [KEY_BITS-1:0] rq_key;

  chs_front #(.KeyBits(KEY_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .key_i,
    .rq_valid_o(rq_valid), .rq_take_i(rq_take),
    .rq_type_o(rq_type), .rq_key_o(rq_key)
  );

  chs_back #(.MaxBuckets(MAX_BUCKETS), .PoolNodes(POOL_NODES), .KeyBits(KEY_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .rq_valid_i(rq_valid), .rq_take_o(rq_take), .rq_type_i(rq_type), .rq_key_i(rq_key),
    .pop, .empty, .found_o, .status_o
  );

endmodule

[design/chs_front.sv]
// Input stage: classify requests and hold them in a short queue for the back end.
module chs_front #(
  parameter int KeyBits = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type_i,
  input  logic [KeyBits-1:0] key_i,
  output logic               rq_valid_o,
  input  logic               rq_take_i,
  output chs_pkg::req_e      rq_type_o,
  output logic [KeyBits-1:0] rq_key_o
);

  localparam int Depth = 2;

  chs_pkg::req_e      type_q [Depth];
  logic [KeyBits-1:0] key_q  [Depth];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;
  logic               put;
  chs_pkg::req_e      kind;

  assign full = (cnt_q == 2'd2);
  assign put  = push && !full;
  assign rq_valid_o = (cnt_q != 2'd0);
  assign rq_type_o  = type_q[rd_q];
  assign rq_key_o   = key_q[rd_q];

  // spare code behaves as a lookup
  always_comb begin
    unique case (req_type_i)
      chs_pkg::REQ_INSERT: kind = chs_pkg::REQ_INSERT;
      chs_pkg::REQ_REMOVE: kind = chs_pkg::REQ_REMOVE;
      default:             kind = chs_pkg::REQ_LOOKUP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      type_q[wr_q] <= kind;
      key_q[wr_q]  <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (put) wr_q <= ~wr_q;
      if (rq_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, put} - {1'b0, rq_take_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rq_take_i |-> rq_valid_o)
    else $error("take from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put && !rq_take_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push lost");

endmodule

[design/chs_back.sv]
// Back end: hash, chain walk, insert and remove on the bucket and node memories.
module chs_back #(
  parameter int MaxBuckets = 256,
  parameter int PoolNodes  = 1024,
  parameter int KeyBits    = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               rq_valid_i,
  output logic               rq_take_o,
  input  chs_pkg::req_e      rq_type_i,
  input  logic [KeyBits-1:0] rq_key_i,
  input  logic               pop,
  output logic               empty,
  output logic               found_o,
  output logic [1:0]         status_o
);

  localparam int BW = $clog2(MaxBuckets + 1);
  localparam int BI = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int NW = $clog2(PoolNodes + 1);
  localparam int NI = $clog2(PoolNodes);
  localparam logic [NW-1:0] Nil = NW'(PoolNodes);
  localparam int MW = KeyBits + 1;

  chs_pkg::back_state_e st_q, st_d;

  logic [BW-1:0]      bcnt_q;
  logic [NW-1:0]      head_mem [MaxBuckets];
  logic [MaxBuckets-1:0] hvalid_q;
  logic [KeyBits-1:0] nkey_mem [PoolNodes];
  logic [NW-1:0]      nlink_mem [PoolNodes];

  chs_pkg::req_e      req_q;
  logic [KeyBits-1:0] key_q;
  logic [MW-1:0]      rem_q;
  logic [MW-1:0]      div_q;
  logic [5:0]         sh_q;
  logic [NW-1:0]      cur_q, prev_q, curlink_q, free_q, fresh_q, newn_q;
  logic [NW-1:0]      hrd_q, lrd_q;
  logic [KeyBits-1:0] krd_q;
  logic [NW-1:0]      guard_q;
  logic               found_q, out_v_q, fout_q;
  logic [1:0]         sout_q;
  logic [NW-1:0]      freelink_q;
  logic [BI-1:0]      bidx;
  logic               any_chain;

  assign bidx      = BI'(rem_q);
  assign any_chain = |hvalid_q;
  assign empty     = !out_v_q;
  assign found_o   = fout_q;
  assign status_o  = sout_q;
  assign rq_take_o = (st_q == chs_pkg::BK_IDLE) && rq_valid_i && !out_v_q;

  // memory ports: registered reads
  logic           h_we;  logic [NW-1:0] h_wd;
  logic           k_we;  logic           l_we;
  logic [NI-1:0]  n_addr; logic [NW-1:0] l_wd;
  logic [NI-1:0]  rd_addr;

  always_ff @(posedge clk_i) begin
    hrd_q <= head_mem[bidx];
    if (h_we) head_mem[bidx] <= h_wd;
  end
  always_ff @(posedge clk_i) begin
    krd_q <= nkey_mem[rd_addr];
    lrd_q <= nlink_mem[rd_addr];
    if (k_we) nkey_mem[n_addr] <= key_q;
    if (l_we) nlink_mem[n_addr] <= l_wd;
  end

  logic [NW-1:0] head_val;
  assign head_val = hvalid_q[bidx] ? hrd_q : Nil;

  always_comb begin
    st_d = st_q; h_we = 1'b0; h_wd = Nil; k_we = 1'b0; l_we = 1'b0;
    n_addr = NI'(cur_q); l_wd = Nil; rd_addr = NI'(cur_q);
    unique case (st_q)
      chs_pkg::BK_IDLE:     if (rq_take_o) st_d = chs_pkg::BK_MOD;
      chs_pkg::BK_MOD:      if (sh_q == 6'd0 && rem_q < div_q) st_d = chs_pkg::BK_HEAD;
      chs_pkg::BK_HEAD:     st_d = chs_pkg::BK_HWAIT;
      chs_pkg::BK_HWAIT:    st_d = chs_pkg::BK_NODE;
      chs_pkg::BK_NODE: begin
        rd_addr = NI'(cur_q);
        if (cur_q >= Nil || guard_q > Nil) st_d = chs_pkg::BK_ACT;
        else st_d = chs_pkg::BK_NWAIT;
      end
      chs_pkg::BK_NWAIT: begin
        if (krd_q == key_q) st_d = chs_pkg::BK_ACT;
        else st_d = chs_pkg::BK_NODE;
      end
      chs_pkg::BK_ACT: begin
        rd_addr = NI'(free_q);
        st_d = chs_pkg::BK_OUT;
        if (req_q == chs_pkg::REQ_INSERT && !found_q) begin
          if (free_q < Nil) st_d = chs_pkg::BK_FREEWAIT;
          else if (fresh_q < Nil) st_d = chs_pkg::BK_FREE;
        end else if (req_q == chs_pkg::REQ_REMOVE && found_q) begin
          st_d = chs_pkg::BK_UNLINK;
        end
      end
      chs_pkg::BK_FREEWAIT: st_d = chs_pkg::BK_FREE;
      chs_pkg::BK_FREE: begin
        // write new node, link from tail or head
        n_addr = NI'(newn_q); k_we = 1'b1; l_we = 1'b1; l_wd = Nil;
        if (prev_q < Nil) st_d = chs_pkg::BK_UNLINK;
        else begin
          h_we = 1'b1; h_wd = newn_q; st_d = chs_pkg::BK_OUT;
        end
      end
      chs_pkg::BK_UNLINK: begin
        st_d = chs_pkg::BK_OUT;
        if (req_q == chs_pkg::REQ_INSERT) begin
          n_addr = NI'(prev_q); l_we = 1'b1; l_wd = newn_q;
        end else begin
          if (prev_q < Nil) begin
            n_addr = NI'(prev_q); l_we = 1'b1; l_wd = curlink_q;
          end else begin
            h_we = 1'b1; h_wd = curlink_q;
          end
        end
      end
      chs_pkg::BK_OUT: begin
        // return removed node to free list
        if (req_q == chs_pkg::REQ_REMOVE && found_q) begin
          n_addr = NI'(cur_q); l_we = 1'b1; l_wd = free_q;
        end
        st_d = chs_pkg::BK_IDLE;
      end
      default: st_d = chs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      chs_pkg::BK_IDLE: if (rq_take_o) begin
        req_q <= rq_type_i; key_q <= rq_key_i;
        rem_q <= MW'(rq_key_i);
        div_q <= MW'(bcnt_q) << (KeyBits - BW + 1);
        sh_q  <= 6'(KeyBits - BW + 1);
      end
      chs_pkg::BK_MOD: begin
        // restoring reduction: each cycle either subtracts the shifted divisor or shifts it right
        if (rem_q >= div_q) rem_q <= rem_q - div_q;
        else if (sh_q != 6'd0) begin
          div_q <= div_q >> 1; sh_q <= sh_q - 6'd1;
        end
        prev_q <= Nil; guard_q <= '0; found_q <= 1'b0;
      end
      chs_pkg::BK_HWAIT: cur_q <= head_val;
      chs_pkg::BK_NWAIT: if (krd_q == key_q) begin
        found_q <= 1'b1; curlink_q <= lrd_q;
      end else begin
        prev_q <= cur_q; cur_q <= lrd_q; guard_q <= guard_q + NW'(1);
      end
      chs_pkg::BK_ACT: begin
        fout_q <= found_q;
        sout_q <= chs_pkg::ST_DONE;
        if (req_q == chs_pkg::REQ_INSERT) begin
          if (found_q) sout_q <= chs_pkg::ST_DUP;
          else if (free_q < Nil) newn_q <= free_q;
          else if (fresh_q < Nil) newn_q <= fresh_q;
          else sout_q <= chs_pkg::ST_FULL;
        end else if (req_q == chs_pkg::REQ_REMOVE && !found_q) begin
          sout_q <= chs_pkg::ST_ABSENT;
        end
      end
      chs_pkg::BK_FREEWAIT: freelink_q <= lrd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= chs_pkg::BK_IDLE; bcnt_q <= BW'(16 > MaxBuckets ? MaxBuckets : 16);
      hvalid_q <= '0; free_q <= Nil; fresh_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i && !any_chain) begin
        if (cfg_wdata_i == 9'd0) bcnt_q <= BW'(1);
        else if (32'(cfg_wdata_i) > MaxBuckets) bcnt_q <= BW'(MaxBuckets);
        else bcnt_q <= BW'(cfg_wdata_i);
      end
      if (h_we) hvalid_q[bidx] <= (h_wd != Nil);
      if (st_q == chs_pkg::BK_FREE) begin
        if (free_q < Nil) free_q <= freelink_q;
        else fresh_q <= fresh_q + NW'(1);
      end
      if (st_q == chs_pkg::BK_OUT) begin
        out_v_q <= 1'b1;
        if (req_q == chs_pkg::REQ_REMOVE && found_q) free_q <= cur_q;
      end else if (pop && out_v_q) out_v_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_take_o |-> st_q == chs_pkg::BK_IDLE && !out_v_q)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fresh_q <= Nil)
    else $error("fresh count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == chs_pkg::BK_OUT |=> out_v_q)
    else $error("result not posted");

endmodule

[dv/chained_hash_set_unit_test.sv]
// Testbench for the chained hash set: directed and random requests against a set model.
`timescale 1ns / 100ps

module chained_hash_set_unit_test;

  localparam int NBUCKETS = 256;
  localparam int NNODES   = 1024;
  localparam int NIL      = NNODES;
  localparam int SETTLE   = 80;
  localparam int WD_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic              found;
    chs_pkg::status_e  st;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type_i = chs_pkg::REQ_LOOKUP;
  logic [30:0] key_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        found_o;
  logic [1:0]  status_o;

  chained_hash_set_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .req_type_i, .key_i,
    .empty, .pop, .found_o, .status_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // set model
  int          bucket_cnt;
  int          head_q [NBUCKETS];
  logic [30:0] node_key_q [NNODES];
  int          node_next_q [NNODES];
  int          free_top;
  int          fresh_used;
  int          live_cnt;
  logic [30:0] recent_keys [$];

  answer_t answers_due [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  function automatic void set_reset();
    bucket_cnt = 16;
    for (int i = 0; i < NBUCKETS; i++) head_q[i] = NIL;
    free_top = NIL;
    fresh_used = 0;
    live_cnt = 0;
  endfunction

  function automatic void set_config(logic [8:0] v);
    int n;
    if (live_cnt != 0) return;
    n = v;
    if (n == 0) n = 1;
    if (n > NBUCKETS) n = NBUCKETS;
    bucket_cnt = n;
  endfunction

  function automatic answer_t set_apply(chs_pkg::req_e r, logic [30:0] k);
    answer_t a;
    int b, prev, cur, last, n;
    b = k % bucket_cnt;
    prev = NIL;
    last = NIL;
    cur = head_q[b];
    a.found = 1'b0;
    a.st = chs_pkg::ST_DONE;
    while (cur != NIL) begin
      if (node_key_q[cur] == k) begin
        a.found = 1'b1;
        break;
      end
      prev = cur;
      last = cur;
      cur = node_next_q[cur];
    end
    if (r == chs_pkg::REQ_INSERT) begin
      if (a.found) a.st = chs_pkg::ST_DUP;
      else begin
        if (free_top != NIL) begin
          n = free_top;
          free_top = node_next_q[n];
        end else if (fresh_used < NNODES) begin
          n = fresh_used;
          fresh_used++;
        end else n = NIL;
        if (n == NIL) a.st = chs_pkg::ST_FULL;
        else begin
          node_key_q[n] = k;
          node_next_q[n] = NIL;
          if (last != NIL) node_next_q[last] = n;
          else head_q[b] = n;
          live_cnt++;
        end
      end
    end else if (r == chs_pkg::REQ_REMOVE) begin
      if (!a.found) a.st = chs_pkg::ST_ABSENT;
      else begin
        if (prev != NIL) node_next_q[prev] = node_next_q[cur];
        else head_q[b] = node_next_q[cur];
        node_next_q[cur] = free_top;
        free_top = cur;
        live_cnt--;
      end
    end
    return a;
  endfunction

  task automatic send_req(chs_pkg::req_e r, logic [30:0] k);
    int gap;
    push <= 1'b1;
    req_type_i <= r;
    key_i <= k;
    do @(posedge clk_i); while (full);
    answers_due.push_back(set_apply(r, k));
    if (r == chs_pkg::REQ_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    push <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [8:0] v);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    set_config(v);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 9'($urandom);
  endtask

  task automatic clear_table();
    for (int b = 0; b < bucket_cnt; b++)
      while (head_q[b] != NIL) send_req(chs_pkg::REQ_REMOVE, node_key_q[head_q[b]]);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result found=%0b status=%0d", $time, found_o, status_o);
        errors++;
      end else begin
        answer_t a;
        a = answers_due.pop_front();
        if (found_o !== a.found) begin
          $display("%0t: found expected %0b actual %0b", $time, a.found, found_o);
          errors++;
        end
        if (status_o !== a.st) begin
          $display("%0t: status expected %0d actual %0d", $time, a.st, status_o);
          errors++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("chained_hash_set_unit regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_req(chs_pkg::REQ_LOOKUP, 31'h0);
    send_req(chs_pkg::REQ_REMOVE, 31'h0);
    send_req(chs_pkg::REQ_INSERT, 31'h0);
    send_req(chs_pkg::REQ_INSERT, 31'h0);
    send_req(chs_pkg::REQ_LOOKUP, 31'h0);
    send_req(chs_pkg::REQ_INSERT, 31'h7fff_ffff);
    send_req(chs_pkg::REQ_SPARE, 31'h7fff_ffff);
    send_req(chs_pkg::REQ_SPARE, 31'h1234);
    // three keys in one bucket, drop the middle one
    send_req(chs_pkg::REQ_INSERT, 31'd16);
    send_req(chs_pkg::REQ_INSERT, 31'd32);
    send_req(chs_pkg::REQ_INSERT, 31'd48);
    send_req(chs_pkg::REQ_REMOVE, 31'd32);
    send_req(chs_pkg::REQ_LOOKUP, 31'd48);
    send_req(chs_pkg::REQ_LOOKUP, 31'd32);
    send_req(chs_pkg::REQ_REMOVE, 31'd32);
    send_req(chs_pkg::REQ_INSERT, 31'd64);
    send_req(chs_pkg::REQ_REMOVE, 31'h7fff_ffff);
    send_req(chs_pkg::REQ_LOOKUP, 31'h5555_5555);
    send_req(chs_pkg::REQ_INSERT, 31'h2aaa_aaaa);
    // table holds keys: this write must be ignored
    write_buckets(9'd1);
    send_req(chs_pkg::REQ_LOOKUP, 31'd48);
    clear_table();
  endtask

  task automatic test_random(int count);
    chs_pkg::req_e r;
    logic [30:0]   k;
    int            pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40 && recent_keys.size() != 0)
        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (pick < 70) k = 31'($urandom_range(600));
      else if (pick < 75)
        k = (pick & 1) ? 31'h7fff_ffff : 31'(31'h7fff_ffff - $urandom_range(300));
      else k = 31'($urandom);
      pick = $urandom_range(99);
      if (pick < 4) r = chs_pkg::REQ_SPARE;
      else if (pick < 30) r = chs_pkg::REQ_LOOKUP;
      else if (pick < ((live_cnt > 40) ? 75 : 55)) r = chs_pkg::REQ_REMOVE;
      else r = chs_pkg::REQ_INSERT;
      send_req(r, k);
    end
  endtask

  task automatic test_pool_full();
    write_buckets(9'd256);
    for (int i = 0; i < NNODES + 6; i++) send_req(chs_pkg::REQ_INSERT, 31'(i * 7 + 3));
    send_req(chs_pkg::REQ_LOOKUP, 31'd3);
    send_req(chs_pkg::REQ_REMOVE, 31'd10);
    send_req(chs_pkg::REQ_INSERT, 31'h7fff_fff0);
    send_req(chs_pkg::REQ_INSERT, 31'h7fff_fff1);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 30; i++) send_req(chs_pkg::REQ_INSERT, 31'($urandom_range(200)));
    clear_table();
  endtask

  task automatic test_settings();
    logic [8:0] settings [7] = '{9'd16, 9'd1, 9'd256, 9'd0, 9'd511, 9'd17, 9'd3};
    int stall_modes [4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{27, 27}};
    for (int s = 0; s < 7; s++) begin
      write_buckets((s == 6) ? 9'($urandom) : settings[s]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = stall_modes[m][0];
        recv_stall_pct = stall_modes[m][1];
        test_random(10);
      end
      clear_table();
    end
  endtask

  initial begin
    set_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_settings();
    test_pool_full();
    quiesce();
    if (errors == 0) $display("chained_hash_set_unit regression: pass");
    else $display("chained_hash_set_unit regression: fail");
    $finish;
  end

endmodule
